// ===== rtl/tlb_pkg.sv =====
// Shared constants, types and helper functions for the TLB page table translator.
`timescale 1ns / 1ps

package tlb_pkg;

  // Sizing
  localparam int TLB_ENTRIES  = 16;
  localparam int PAGE_ENTRIES = 256;
  localparam int PAGE_BYTES   = 256;

  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int PAGE_IDX_W  = $clog2(PAGE_ENTRIES);
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

  // Field widths fixed by the address format
  localparam int ADDR_W     = 16;
  localparam int PAGE_W     = 8;
  localparam int OFFSET_W   = 8;
  localparam int FRAME_W    = 8;
  localparam int COUNT_W    = 32;
  localparam int FREE_W     = FRAME_W + 1;
  localparam int PHYS_CALC_W = FRAME_W + PAGE_SHIFT + 1;

  // Free frame counter stops here
  localparam logic [FREE_W-1:0] FRAME_LIMIT = FREE_W'(256);

  // Refill of one TLB entry at the FIFO slot
  typedef struct packed {
    logic               en;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_fill_t;

  // Compare result for the entry under the scan index
  typedef struct packed {
    logic               match;
    logic [FRAME_W-1:0] frame;
  } tlb_probe_t;

  // Page number to page table index (modulo table depth)
  function automatic logic [PAGE_IDX_W-1:0] page_index(input logic [PAGE_W-1:0] page);
    logic [PAGE_W+PAGE_IDX_W-1:0] wide;
    wide = {{PAGE_IDX_W{1'b0}}, page};
    return wide[PAGE_IDX_W-1:0];
  endfunction

  // Saturating counter step
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/tlb_entries.sv =====
// TLB entry storage with one shared tag comparator and FIFO refill pointer.
`timescale 1ns / 1ps

module tlb_entries (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tlb_pkg::TLB_IDX_W-1:0] scan_index,
  input  logic [tlb_pkg::PAGE_W-1:0]    page,
  input  tlb_pkg::tlb_fill_t            fill,
  output tlb_pkg::tlb_probe_t           probe
);

  logic [tlb_pkg::PAGE_W-1:0]    tag   [tlb_pkg::TLB_ENTRIES];
  logic [tlb_pkg::FRAME_W-1:0]   frame [tlb_pkg::TLB_ENTRIES];
  logic [tlb_pkg::TLB_ENTRIES-1:0] valid;
  logic [tlb_pkg::TLB_IDX_W-1:0] fifo_pointer;
  logic [tlb_pkg::TLB_IDX_W-1:0] fifo_pointer_next;

  // Pointer wraps at the entry count
  always_comb begin
    if (fifo_pointer == tlb_pkg::TLB_IDX_W'(tlb_pkg::TLB_ENTRIES - 1)) begin
      fifo_pointer_next = '0;
    end else begin
      fifo_pointer_next = fifo_pointer + tlb_pkg::TLB_IDX_W'(1);
    end
  end

  // Control state: valid bits and FIFO pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      fifo_pointer <= '0;
    end else if (fill.en) begin
      valid[fifo_pointer] <= 1'b1;
      fifo_pointer        <= fifo_pointer_next;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (fill.en) begin
      tag[fifo_pointer]   <= fill.page;
      frame[fifo_pointer] <= fill.frame;
    end
  end

  // Shared comparator on the entry under scan
  assign probe.match = valid[scan_index] && (tag[scan_index] == page);
  assign probe.frame = frame[scan_index];

`ifndef NO_ASSERTIONS
  // A refill always leaves its slot valid
  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    fill.en |=> valid[$past(fifo_pointer)])
    else $error("refilled TLB slot not valid");

  // Pointer moves only on a refill
  a_ptr_moves_on_fill: assert property (@(posedge clk) disable iff (rst)
    !fill.en |=> $stable(fifo_pointer))
    else $error("FIFO pointer moved without refill");

  // Pointer stays in range
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    fifo_pointer <= tlb_pkg::TLB_IDX_W'(tlb_pkg::TLB_ENTRIES - 1))
    else $error("FIFO pointer out of range");
`endif

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// Top level: request sequencer, page table, frame allocator and hit/fault counters.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    logical_address
//   out      out  out_valid/out_ready  physical_address, frame_number, tlb_hit,
//                                      page_fault, hit_count, fault_count
//
// One request at a time. The TLB is scanned one entry per cycle by one tag
// comparator, stopping at the first valid match. A hit goes from the scan to
// the result; a miss goes through scan, page table read, update and result.
// in_ready is high in idle, even while a result waits on out_ready.
// Reset clears TLB and page valid bits, pointers and counters at once.
`timescale 1ns / 1ps

module tlb_page_table_translator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tlb_pkg::ADDR_W-1:0]   logical_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tlb_pkg::ADDR_W-1:0]   physical_address,
  output logic [tlb_pkg::FRAME_W-1:0]  frame_number,
  output logic                         tlb_hit,
  output logic                         page_fault,
  output logic [tlb_pkg::COUNT_W-1:0]  hit_count,
  output logic [tlb_pkg::COUNT_W-1:0]  fault_count
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_PT_READ = 3'd2;
  localparam logic [2:0] S_PT_WAIT = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]                        state;
  logic [tlb_pkg::PAGE_W-1:0]        page_q;
  logic [tlb_pkg::OFFSET_W-1:0]      offset_q;
  logic [tlb_pkg::TLB_IDX_W-1:0]     scan_idx;
  logic [tlb_pkg::FRAME_W-1:0]       frame_q;
  logic                              hit_q;
  logic                              fault_q;
  logic                              pvalid_q;
  logic [tlb_pkg::FREE_W-1:0]        next_free_frame;
  logic [tlb_pkg::COUNT_W-1:0]       hit_total;
  logic [tlb_pkg::COUNT_W-1:0]       fault_total;

  // Page table: frame memory plus valid flops
  logic [tlb_pkg::FRAME_W-1:0]       page_frame [tlb_pkg::PAGE_ENTRIES];
  logic [tlb_pkg::PAGE_ENTRIES-1:0]  page_valid;
  logic [tlb_pkg::FRAME_W-1:0]       pt_rdata;
  logic [tlb_pkg::PAGE_IDX_W-1:0]    pt_index;

  tlb_pkg::tlb_fill_t                fill;
  tlb_pkg::tlb_probe_t               probe;
  logic [tlb_pkg::FRAME_W-1:0]       miss_frame;
  logic                              allocate;
  logic                              out_free;
  logic [tlb_pkg::PHYS_CALC_W-1:0]   phys_calc;

  assign pt_index   = tlb_pkg::page_index(page_q);
  assign allocate   = (state == S_PT_WAIT) && !pvalid_q;
  assign miss_frame = pvalid_q ? pt_rdata : next_free_frame[tlb_pkg::FRAME_W-1:0];
  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;

  // TLB refill on every miss
  assign fill.en    = (state == S_PT_WAIT);
  assign fill.page  = page_q;
  assign fill.frame = miss_frame;

  tlb_entries u_entries (
    .clk        (clk),
    .rst        (rst),
    .scan_index (scan_idx),
    .page       (page_q),
    .fill       (fill),
    .probe      (probe)
  );

  // Physical address: frame times page size plus offset, low bits kept
  assign phys_calc = (tlb_pkg::PHYS_CALC_W'(frame_q) << tlb_pkg::PAGE_SHIFT)
                   + tlb_pkg::PHYS_CALC_W'(offset_q);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      scan_idx        <= '0;
      next_free_frame <= '0;
      hit_total       <= '0;
      fault_total     <= '0;
      page_valid      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Result valid: set when a finished request moves out, cleared when taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_SCAN;
            scan_idx <= '0;
          end
        end
        S_SCAN: begin
          if (probe.match) begin
            hit_total <= tlb_pkg::sat_inc(hit_total);
            state     <= S_DONE;
          end else if (scan_idx == tlb_pkg::TLB_IDX_W'(tlb_pkg::TLB_ENTRIES - 1)) begin
            state <= S_PT_READ;
          end else begin
            scan_idx <= scan_idx + tlb_pkg::TLB_IDX_W'(1);
          end
        end
        S_PT_READ: begin
          state <= S_PT_WAIT;
        end
        S_PT_WAIT: begin
          if (allocate) begin
            page_valid[pt_index] <= 1'b1;
            fault_total          <= tlb_pkg::sat_inc(fault_total);
            if (next_free_frame < tlb_pkg::FRAME_LIMIT) begin
              next_free_frame <= next_free_frame + tlb_pkg::FREE_W'(1);
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload and per-request working values
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      page_q   <= logical_address[tlb_pkg::ADDR_W-1:tlb_pkg::OFFSET_W];
      offset_q <= logical_address[tlb_pkg::OFFSET_W-1:0];
      hit_q    <= 1'b0;
      fault_q  <= 1'b0;
    end
    if (state == S_SCAN && probe.match) begin
      frame_q <= probe.frame;
      hit_q   <= 1'b1;
    end
    if (state == S_PT_READ) begin
      pvalid_q <= page_valid[pt_index];
    end
    if (state == S_PT_WAIT) begin
      frame_q <= miss_frame;
      fault_q <= !pvalid_q;
    end
  end

  // Page table memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (allocate) begin
      page_frame[pt_index] <= miss_frame;
    end
    pt_rdata <= page_frame[pt_index];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      physical_address <= phys_calc[tlb_pkg::ADDR_W-1:0];
      frame_number     <= frame_q;
      tlb_hit          <= hit_q;
      page_fault       <= fault_q;
      hit_count        <= hit_total;
      fault_count      <= fault_total;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is never both a hit and a fault
  a_hit_xor_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tlb_hit && page_fault))
    else $error("result flags both hit and fault");

  // Counters include the reported event
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tlb_hit) |-> (hit_count != '0))
    else $error("hit reported with zero hit count");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && page_fault) |-> (fault_count != '0))
    else $error("fault reported with zero fault count");

  // Free frame counter never passes its limit
  a_free_limit: assert property (@(posedge clk) disable iff (rst)
    next_free_frame <= tlb_pkg::FRAME_LIMIT)
    else $error("free frame counter past limit");

  // An allocated page is marked valid afterwards
  a_alloc_marks_valid: assert property (@(posedge clk) disable iff (rst)
    allocate |=> page_valid[$past(pt_index)])
    else $error("allocated page not marked valid");
`endif

endmodule

// ===== dv/tlb_page_table_translator_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the TLB page table translator: in-order prediction and check of every translation.

module tlb_page_table_translator_tb;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          HOT_PAGES    = 12;
  localparam int          PHASE_ITEMS  = 462;
  localparam int          SETTLE_CYCLES = 40;

  // One translation result as seen on the output channel
  typedef struct {
    logic [tlb_pkg::ADDR_W-1:0]  phys;
    logic [tlb_pkg::FRAME_W-1:0] frame;
    logic                        hit;
    logic                        fault;
    logic [tlb_pkg::COUNT_W-1:0] hits;
    logic [tlb_pkg::COUNT_W-1:0] faults;
  } xlate_t;

  // Mirror of TLB, page table, frame allocator and counters, plus pending translations
  class translation_checker;
    logic [tlb_pkg::PAGE_W-1:0]    tag      [tlb_pkg::TLB_ENTRIES];
    logic [tlb_pkg::FRAME_W-1:0]   tlb_fr   [tlb_pkg::TLB_ENTRIES];
    logic                          tlb_ok   [tlb_pkg::TLB_ENTRIES];
    logic [tlb_pkg::TLB_IDX_W-1:0] fill_ptr;
    logic [tlb_pkg::FRAME_W-1:0]   page_fr  [tlb_pkg::PAGE_ENTRIES];
    logic                          page_ok  [tlb_pkg::PAGE_ENTRIES];
    logic [tlb_pkg::FREE_W-1:0]    free_frame;
    logic [tlb_pkg::COUNT_W-1:0]   hit_total;
    logic [tlb_pkg::COUNT_W-1:0]   fault_total;
    xlate_t                        pending_xlations[$];
    int                            errors;

    function new();
      foreach (tag[i]) begin
        tag[i]    = '0;
        tlb_fr[i] = '0;
        tlb_ok[i] = 1'b0;
      end
      foreach (page_ok[i]) begin
        page_fr[i] = '0;
        page_ok[i] = 1'b0;
      end
      fill_ptr    = '0;
      free_frame  = '0;
      hit_total   = '0;
      fault_total = '0;
      errors      = 0;
    endfunction

    // Translate an accepted request and queue the expected result
    function void note_request(logic [tlb_pkg::ADDR_W-1:0] addr);
      logic [tlb_pkg::PAGE_W-1:0]   page;
      logic [tlb_pkg::OFFSET_W-1:0] offset;
      logic [tlb_pkg::FRAME_W-1:0]  frame;
      xlate_t                       r;
      int                           idx;
      page   = addr[tlb_pkg::ADDR_W-1 -: tlb_pkg::PAGE_W];
      offset = addr[tlb_pkg::OFFSET_W-1:0];
      frame  = '0;
      r.hit  = 1'b0;
      r.fault = 1'b0;
      // lowest matching valid entry wins
      for (int i = 0; i < tlb_pkg::TLB_ENTRIES; i++) begin
        if (!r.hit && tlb_ok[i] && tag[i] == page) begin
          r.hit = 1'b1;
          frame = tlb_fr[i];
        end
      end
      if (r.hit) begin
        if (hit_total != '1) hit_total = hit_total + 1'b1;
      end else begin
        idx = int'(page) % tlb_pkg::PAGE_ENTRIES;
        if (page_ok[idx]) begin
          frame = page_fr[idx];
        end else begin
          // allocate; counter parks at the limit and its low bits give frame 0
          frame = free_frame[tlb_pkg::FRAME_W-1:0];
          if (free_frame < tlb_pkg::FRAME_LIMIT) free_frame = free_frame + 1'b1;
          page_fr[idx] = frame;
          page_ok[idx] = 1'b1;
          r.fault = 1'b1;
          if (fault_total != '1) fault_total = fault_total + 1'b1;
        end
        // FIFO refill on every miss
        tag[fill_ptr]    = page;
        tlb_fr[fill_ptr] = frame;
        tlb_ok[fill_ptr] = 1'b1;
        fill_ptr = (int'(fill_ptr) == tlb_pkg::TLB_ENTRIES - 1) ? '0 : fill_ptr + 1'b1;
      end
      r.phys   = tlb_pkg::ADDR_W'(int'(frame) * tlb_pkg::PAGE_BYTES + int'(offset));
      r.frame  = frame;
      r.hits   = hit_total;
      r.faults = fault_total;
      pending_xlations.push_back(r);
    endfunction

    // Compare an accepted result against the oldest pending translation
    function void check_result(xlate_t got);
      xlate_t want;
      if (pending_xlations.size() == 0) begin
        $error("unexpected result: physical_address %h, no request outstanding", got.phys);
        errors++;
        return;
      end
      want = pending_xlations.pop_front();
      if (got.phys !== want.phys) begin
        $error("physical_address expected %h actual %h", want.phys, got.phys);
        errors++;
      end
      if (got.frame !== want.frame) begin
        $error("frame_number expected %h actual %h", want.frame, got.frame);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("tlb_hit expected %b actual %b", want.hit, got.hit);
        errors++;
      end
      if (got.fault !== want.fault) begin
        $error("page_fault expected %b actual %b", want.fault, got.fault);
        errors++;
      end
      if (got.hits !== want.hits) begin
        $error("hit_count expected %0d actual %0d", want.hits, got.hits);
        errors++;
      end
      if (got.faults !== want.faults) begin
        $error("fault_count expected %0d actual %0d", want.faults, got.faults);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [tlb_pkg::ADDR_W-1:0]  logical_address;
  logic                        out_valid;
  logic                        out_ready;
  logic [tlb_pkg::ADDR_W-1:0]  physical_address;
  logic [tlb_pkg::FRAME_W-1:0] frame_number;
  logic                        tlb_hit;
  logic                        page_fault;
  logic [tlb_pkg::COUNT_W-1:0] hit_count;
  logic [tlb_pkg::COUNT_W-1:0] fault_count;

  translation_checker          xlate = new();
  int                          send_idle_pct = 0;
  int                          recv_stall_pct = 0;
  int unsigned                 cycle_count = 0;
  logic [tlb_pkg::PAGE_W-1:0]  hot_page [HOT_PAGES];
  logic [tlb_pkg::PAGE_W-1:0]  sweep_page = '0;

  tlb_page_table_translator u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .frame_number     (frame_number),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_count        (hit_count),
    .fault_count      (fault_count)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic [tlb_pkg::ADDR_W-1:0] addr);
    in_valid        <= 1'b1;
    logical_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    xlate.note_request(addr);
  endtask

  // Random idle cycles on the request side
  task automatic idle_sender();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off new requests until every pending result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (xlate.pending_xlations.size() != 0) @(posedge clk);
  endtask

  // Mostly a small working set (hits), new pages in sweep order (faults), some noise
  function automatic logic [tlb_pkg::ADDR_W-1:0] next_address();
    int                         r;
    logic [tlb_pkg::PAGE_W-1:0] page;
    r = $urandom_range(99);
    if (r < 60) begin
      page = hot_page[$urandom_range(HOT_PAGES - 1)];
    end else if (r < 85) begin
      page       = sweep_page;
      sweep_page = sweep_page + 1'b1;
    end else begin
      page = tlb_pkg::PAGE_W'($urandom_range(255));
    end
    if ($urandom_range(3) == 0) hot_page[$urandom_range(HOT_PAGES - 1)] = page;
    return {page, tlb_pkg::OFFSET_W'($urandom_range(255))};
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      idle_sender();
      send_request(next_address());
    end
  endtask

  // Result side: random backpressure, check each accepted result
  initial begin
    xlate_t got;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.phys   = physical_address;
        got.frame  = frame_number;
        got.hit    = tlb_hit;
        got.fault  = page_fault;
        got.hits   = hit_count;
        got.faults = fault_count;
        xlate.check_result(got);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    logical_address <= '0;
    foreach (hot_page[i]) hot_page[i] = tlb_pkg::PAGE_W'($urandom_range(255));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first fault, then hit with max offset; top page likewise
    send_request(16'h0000);
    send_request(16'h00FF);
    send_request(16'hFFFF);
    send_request(16'hFF00);
    // fill remaining TLB slots, then wrap the FIFO and evict page 0
    for (int p = 1; p <= 15; p++) begin
      send_request({tlb_pkg::PAGE_W'(p), tlb_pkg::OFFSET_W'(p * 17)});
    end
    // miss on a page that is already mapped: refill without fault
    send_request(16'h0055);
    send_request(16'hFF80);
    // hit in the last TLB slot (longest scan)
    send_request(16'h0E12);
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS);
    wait_drained();
    run_phase(73, 0, PHASE_ITEMS);
    wait_drained();
    run_phase(0, 73, PHASE_ITEMS);
    wait_drained();
    run_phase(33, 33, PHASE_ITEMS);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (xlate.errors == 0 && xlate.pending_xlations.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
